// File: hdl/sttk_pkg.sv
// Shared types and token kind codes for the source text tokenizer.
package sttk_pkg;

  // Token kinds as carried on the result channel.
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_NAME    = 5'd1;
  localparam logic [4:0] KIND_INT     = 5'd2;
  localparam logic [4:0] KIND_STR     = 5'd3;
  localparam logic [4:0] KIND_ARROW   = 5'd4;
  localparam logic [4:0] KIND_LPAREN  = 5'd5;
  localparam logic [4:0] KIND_RPAREN  = 5'd6;
  localparam logic [4:0] KIND_EQUAL   = 5'd7;
  localparam logic [4:0] KIND_PLUS    = 5'd8;
  localparam logic [4:0] KIND_MINUS   = 5'd9;
  localparam logic [4:0] KIND_STAR    = 5'd10;
  localparam logic [4:0] KIND_SLASH   = 5'd11;
  localparam logic [4:0] KIND_GT      = 5'd12;
  localparam logic [4:0] KIND_LT      = 5'd13;
  localparam logic [4:0] KIND_COMMA   = 5'd14;
  localparam logic [4:0] KIND_SEMI    = 5'd15;
  localparam logic [4:0] KIND_DOT     = 5'd16;
  localparam logic [4:0] KIND_NEWLINE = 5'd17;
  localparam logic [4:0] KIND_STOP    = 5'd18;

  // Width of the position and length fields on the result channel.
  localparam int unsigned OUT_BITS = 16;

  // One token result.
  typedef struct packed {
    logic [4:0]          kind;
    logic [OUT_BITS-1:0] row;
    logic [OUT_BITS-1:0] col;
    logic [OUT_BITS-1:0] len;
    logic                last;
  } sttk_res_t;

  // Results produced by one input transaction, in order e0 then e1.
  typedef struct packed {
    logic [1:0] n;
    sttk_res_t  e0;
    sttk_res_t  e1;
  } sttk_push_t;

endpackage

// File: hdl/source_text_tokenizer.sv
// Source text tokenizer: one byte per transaction in, token reports out.
// A token's report is written into the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the four-entry result queue has room for two
// results; bytes yielding two reports can fill it, stalling input without backpressure.
// Reset (rst_n low, synchronous): scanner idle at row 1, column 1, result queue empty.
module source_text_tokenizer
  import sttk_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // is_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] row, [31:16] col, [47:32] length
  output logic [4:0]  out_tuser,  // [4:0] kind
  output logic        out_tlast   // last result of the input transaction
);

  sttk_push_t push;
  sttk_res_t  head;
  logic       room;
  logic       step_en;

  // An input transaction completes when the queue can absorb its results.
  assign in_tready = room;
  assign step_en   = in_tvalid && room;

  sttk_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .char_code (in_tdata),
    .is_end    (in_tlast),
    .push      (push)
  );

  sttk_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // Result channel packing.
  assign out_tdata = {head.len, head.col, head.row};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// File: hdl/sttk_core.sv
// Tokenizer state registers and the per-character scanning logic.
module sttk_core
  import sttk_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] char_code,
  input  logic       is_end,
  output sttk_push_t push
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_INT,
    MODE_STR,
    MODE_MINUS,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_HALT
  } mode_t;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  mode_t                 mode_r, mode_nxt;
  logic [POS_BITS-1:0]   cur_row_r, cur_row_nxt;
  logic [POS_BITS-1:0]   cur_col_r, cur_col_nxt;
  logic [POS_BITS-1:0]   start_row_r, start_row_nxt;
  logic [POS_BITS-1:0]   start_col_r, start_col_nxt;
  logic [OUT_BITS-1:0]   tok_len_r, tok_len_nxt;

  // Character classes.
  logic       c_blank, c_alpha, c_digit, c_quote, c_minus, c_slash, c_nl, c_gt;
  logic [4:0] c_sym;

  // Handling of the character as if no token were open.
  logic       idl_v, idl_open, idl_adv;
  sttk_res_t  idl_res;
  mode_t      idl_mode;
  logic [OUT_BITS-1:0] idl_len;

  logic       a_v, b_v, use_idle, adv;
  sttk_res_t  res_a, res_b;

  function automatic logic [OUT_BITS-1:0] clamp_pos(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? '1 : w[OUT_BITS-1:0];
  endfunction

  function automatic sttk_res_t mk_res(input logic [4:0] kind,
                                       input logic [POS_BITS-1:0] row,
                                       input logic [POS_BITS-1:0] col,
                                       input logic [OUT_BITS-1:0] len);
    sttk_res_t r;
    r.kind = kind;
    r.row  = clamp_pos(row);
    r.col  = clamp_pos(col);
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] symbol_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3D:   k = KIND_EQUAL;
      8'h2B:   k = KIND_PLUS;
      8'h2A:   k = KIND_STAR;
      8'h3E:   k = KIND_GT;
      8'h3C:   k = KIND_LT;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      8'h2E:   k = KIND_DOT;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // Classify the incoming byte.
  always_comb begin
    c_blank = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0B) ||
              (char_code == 8'h0C) || (char_code == 8'h0D);
    c_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
              ((char_code >= 8'h41) && (char_code <= 8'h5A));
    c_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    c_quote = (char_code == 8'h22);
    c_minus = (char_code == 8'h2D);
    c_slash = (char_code == 8'h2F);
    c_nl    = (char_code == 8'h0A);
    c_gt    = (char_code == 8'h3E);
    c_sym   = symbol_kind(char_code);
  end

  // Idle-state handling: skip a blank, open a token, emit a one-character token, or stop.
  always_comb begin
    idl_v    = 1'b0;
    idl_open = 1'b0;
    idl_adv  = 1'b1;
    idl_mode = MODE_IDLE;
    idl_len  = '0;
    idl_res  = mk_res(KIND_STOP, cur_row_r, cur_col_r, OUT_BITS'(1));
    priority if (c_blank) begin
    end else if (c_alpha) begin
      idl_open = 1'b1;
      idl_mode = MODE_NAME;
      idl_len  = OUT_BITS'(1);
    end else if (c_digit) begin
      idl_open = 1'b1;
      idl_mode = MODE_INT;
      idl_len  = OUT_BITS'(1);
    end else if (c_quote) begin
      idl_open = 1'b1;
      idl_mode = MODE_STR;
    end else if (c_minus) begin
      idl_open = 1'b1;
      idl_mode = MODE_MINUS;
      idl_len  = OUT_BITS'(1);
    end else if (c_slash) begin
      idl_open = 1'b1;
      idl_mode = MODE_SLASH;
      idl_len  = OUT_BITS'(1);
    end else if (c_sym != KIND_END) begin
      idl_v   = 1'b1;
      idl_res = mk_res(c_sym, cur_row_r, cur_col_r, OUT_BITS'(1));
    end else if (c_nl) begin
      idl_v   = 1'b1;
      idl_res = mk_res(KIND_NEWLINE, cur_row_r, cur_col_r, OUT_BITS'(1));
    end else begin
      // Unknown byte: report it and halt until the end marker.
      idl_v    = 1'b1;
      idl_adv  = 1'b0;
      idl_mode = MODE_HALT;
    end
  end

  // Per-mode next state and result selection.
  always_comb begin
    mode_nxt      = mode_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    tok_len_nxt   = tok_len_r;
    a_v           = 1'b0;
    b_v           = 1'b0;
    res_a         = mk_res(KIND_NAME, start_row_r, start_col_r, tok_len_r);
    res_b         = mk_res(KIND_END, cur_row_r, cur_col_r, '0);
    use_idle      = 1'b0;
    adv           = 1'b0;

    if (is_end) begin
      // Flush any open token, then report the end and return to reset values.
      unique case (mode_r)
        MODE_NAME: begin
          a_v   = 1'b1;
          res_a = mk_res(KIND_NAME, start_row_r, start_col_r, tok_len_r);
        end
        MODE_INT: begin
          a_v   = 1'b1;
          res_a = mk_res(KIND_INT, start_row_r, start_col_r, tok_len_r);
        end
        MODE_STR: begin
          a_v   = 1'b1;
          res_a = mk_res(KIND_STR, start_row_r, start_col_r, tok_len_r);
        end
        MODE_MINUS: begin
          a_v   = 1'b1;
          res_a = mk_res(KIND_MINUS, start_row_r, start_col_r, OUT_BITS'(1));
        end
        MODE_SLASH: begin
          a_v   = 1'b1;
          res_a = mk_res(KIND_SLASH, start_row_r, start_col_r, OUT_BITS'(1));
        end
        default: begin
        end
      endcase
      b_v           = 1'b1;
      mode_nxt      = MODE_IDLE;
      cur_row_nxt   = POS_ONE;
      cur_col_nxt   = POS_ONE;
      start_row_nxt = '0;
      start_col_nxt = '0;
      tok_len_nxt   = '0;
    end else begin
      unique case (mode_r)
        MODE_HALT: begin
        end
        MODE_COMMENT: begin
          if (c_nl) begin
            mode_nxt = MODE_IDLE;
          end
          adv = 1'b1;
        end
        MODE_STR: begin
          if (c_quote) begin
            a_v      = 1'b1;
            res_a    = mk_res(KIND_STR, start_row_r, start_col_r, tok_len_r);
            mode_nxt = MODE_IDLE;
          end else if (tok_len_r != '1) begin
            tok_len_nxt = tok_len_r + OUT_BITS'(1);
          end
          adv = 1'b1;
        end
        MODE_NAME: begin
          if (c_alpha || c_digit) begin
            if (tok_len_r != '1) begin
              tok_len_nxt = tok_len_r + OUT_BITS'(1);
            end
            adv = 1'b1;
          end else begin
            a_v      = 1'b1;
            res_a    = mk_res(KIND_NAME, start_row_r, start_col_r, tok_len_r);
            use_idle = 1'b1;
          end
        end
        MODE_INT: begin
          if (c_digit) begin
            if (tok_len_r != '1) begin
              tok_len_nxt = tok_len_r + OUT_BITS'(1);
            end
            adv = 1'b1;
          end else begin
            a_v      = 1'b1;
            res_a    = mk_res(KIND_INT, start_row_r, start_col_r, tok_len_r);
            use_idle = 1'b1;
          end
        end
        MODE_MINUS: begin
          a_v = 1'b1;
          if (c_gt) begin
            res_a    = mk_res(KIND_ARROW, start_row_r, start_col_r, OUT_BITS'(2));
            mode_nxt = MODE_IDLE;
            adv      = 1'b1;
          end else begin
            res_a    = mk_res(KIND_MINUS, start_row_r, start_col_r, OUT_BITS'(1));
            use_idle = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c_slash) begin
            mode_nxt = MODE_COMMENT;
            adv      = 1'b1;
          end else begin
            a_v      = 1'b1;
            res_a    = mk_res(KIND_SLASH, start_row_r, start_col_r, OUT_BITS'(1));
            use_idle = 1'b1;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        b_v      = idl_v;
        res_b    = idl_res;
        mode_nxt = idl_mode;
        adv      = idl_adv;
        if (idl_open) begin
          start_row_nxt = cur_row_r;
          start_col_nxt = cur_col_r;
          tok_len_nxt   = idl_len;
        end
      end

      // Advance the position past the consumed byte.
      if (adv) begin
        if (c_nl) begin
          cur_row_nxt = (cur_row_r == POS_MAX) ? POS_MAX : cur_row_r + POS_ONE;
          cur_col_nxt = POS_ONE;
        end else begin
          cur_col_nxt = (cur_col_r == POS_MAX) ? POS_MAX : cur_col_r + POS_ONE;
        end
      end
    end
  end

  // Order the results and mark the final one.
  always_comb begin
    push.n  = 2'd0;
    push.e0 = res_a;
    push.e1 = res_b;
    if (step_en) begin
      if (a_v) begin
        push.n = b_v ? 2'd2 : 2'd1;
      end else begin
        push.e0 = res_b;
        push.n  = b_v ? 2'd1 : 2'd0;
      end
    end
    if (push.n == 2'd2) begin
      push.e1.last = 1'b1;
    end else begin
      push.e0.last = 1'b1;
    end
  end

  // Tokenizer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cur_row_r   <= POS_ONE;
      cur_col_r   <= POS_ONE;
      start_row_r <= '0;
      start_col_r <= '0;
      tok_len_r   <= '0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      tok_len_r   <= tok_len_nxt;
    end
  end

  // The end marker always returns the scanner to idle.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && is_end) |=> (mode_r == MODE_IDLE))
    else $error("scanner not idle after end marker");

  // A halted scanner stays halted on ordinary bytes.
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !is_end && (mode_r == MODE_HALT)) |=> (mode_r == MODE_HALT))
    else $error("scanner left halt without end marker");

  // Nothing is produced while halted except on the end marker.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!is_end && (mode_r == MODE_HALT)) |-> (push.n == 2'd0))
    else $error("result produced while halted");

endmodule

// File: hdl/sttk_outq.sv
// Four-entry result queue taking up to two results per cycle.
module sttk_outq
  import sttk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sttk_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output sttk_res_t  out_res
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  sttk_res_t             mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  pop;
  logic [PTR_BITS-1:0]   wr_ptr_p1;

  // Space for a worst-case pair of results.
  assign room      = (cnt_r <= CNT_BITS'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + PTR_BITS'(1);

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_BITS'(push.n);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_BITS'(push.n) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.e1;
    end
  end

  // Occupancy never exceeds the storage.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) + 32'(push.n) - 32'(pop)) <= DEPTH)
    else $error("result queue overflow");

  // Results are only written while there was room for them.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("results pushed without room");

  // A waiting result stays offered and unchanged until it is taken.
  a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
    else $error("waiting result dropped or changed");

endmodule
